// ===== sv/pmgs_pkg.sv =====
package pmgs_pkg;

  typedef struct packed {
    logic [7:0]  deadzone_radius;
    logic [11:0] gain_low;
    logic [11:0] gain_high;
    logic [7:0]  speed_low;
    logic [7:0]  speed_high;
    logic [15:0] idle_limit_ms;
    logic [11:0] axis_scale_x;
    logic [11:0] axis_scale_y;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_DEADZONE_RADIUS = 3'd0,
    REG_GAIN_LOW        = 3'd1,
    REG_GAIN_HIGH       = 3'd2,
    REG_SPEED_LOW       = 3'd3,
    REG_SPEED_HIGH      = 3'd4,
    REG_IDLE_LIMIT_MS   = 3'd5,
    REG_AXIS_SCALE_X    = 3'd6,
    REG_AXIS_SCALE_Y    = 3'd7
  } reg_idx_t;

  localparam cfg_t CFG_RESET = '{
    deadzone_radius: 8'd0,
    gain_low:        12'd64,
    gain_high:       12'd256,
    speed_low:       8'd4,
    speed_high:      8'd24,
    idle_limit_ms:   16'd50,
    axis_scale_x:    12'd256,
    axis_scale_y:    12'd256
  };

  localparam int unsigned DIV_W = 32;

  // Datapath step commanded by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQUARE,
    OP_DEADZONE,
    OP_GAIN_SEL,
    OP_GAIN_DIV,
    OP_GAIN_FIX,
    OP_SCALE,
    OP_SCALE_DIV,
    OP_MOVE,
    OP_ACCUM,
    OP_QUOT_DIV,
    OP_QUOT_FIX,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic interp;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/pmgs_if.sv =====
interface pmgs_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;
  logic [31:0]       now_ms;

  modport source (output valid, output move_x, output move_y, output now_ms, input ready);
  modport sink   (input valid, input move_x, input move_y, input now_ms, output ready);
endinterface

interface pmgs_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] out_x;
  logic signed [7:0] out_y;

  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

// ===== sv/pmgs_div.sv =====
// Unsigned restoring divider, two quotient bits per cycle.
module pmgs_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int WP    = W + (W % 2);
  localparam int STEPS = WP / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [WP:0]   rem_r, rem_nxt;
  logic [WP-1:0] quo_r, quo_nxt;
  logic [WP-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < 2; i++) begin
      rem_nxt = {rem_nxt[WP-1:0], quo_nxt[WP-1]};
      quo_nxt = {quo_nxt[WP-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dvs_r}) begin
        rem_nxt    = rem_nxt - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= WP'(dividend);
      dvs_r <= WP'(divisor);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r[W-1:0];
  assign rem  = rem_r[W-1:0];

endmodule

// ===== sv/pmgs_dp.sv =====
// Shaper datapath: deadzone, speed, gain, axis scaling, accumulation.
module pmgs_dp #(
  parameter int FRAC_DENOM = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pmgs_pkg::cfg_t          cfg,
  input  logic signed [7:0]       move_x,
  input  logic signed [7:0]       move_y,
  input  logic [31:0]             now_ms,
  input  pmgs_pkg::op_t           op,
  output pmgs_pkg::dp_status_t    status,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [7:0]       out_x,
  output logic signed [7:0]       out_y
);

  localparam int DW = pmgs_pkg::DIV_W;
  localparam logic [DW-1:0] DENOM = DW'(FRAC_DENOM);
  localparam logic [24:0]   HALF  = 25'(FRAC_DENOM / 2);

  // sample and per-item working registers
  logic signed [7:0]  mx_r, my_r;
  logic [31:0]        now_r;
  logic [14:0]        sqx_r, sqy_r;
  logic [15:0]        r2_r;
  logic signed [7:0]  mzx_r, mzy_r;
  logic [7:0]         speed_r;
  logic [11:0]        gain_r;
  logic signed [21:0] iprod_r;
  logic [24:0]        pxx_r, pxy_r;
  logic signed [31:0] prodx_r, prody_r;
  logic signed [7:0]  resx_r, resy_r;
  logic signed [7:0]  outx_r, outy_r;
  logic               out_valid_r;

  // state kept between items
  logic signed [31:0] accx_r, accy_r;
  logic signed [7:0]  prevx_r, prevy_r;
  logic [31:0]        prevt_r;

  // divider lanes
  logic          div_start;
  logic [DW-1:0] dvdx, dvdy, dvs;
  logic          donex, doney;
  logic [DW-1:0] quotx, quoty, remx, remy;

  // combinational helpers
  logic signed [15:0] sqx_w, sqy_w;
  logic [15:0]        r2_w;
  logic [15:0]        sqsum;
  logic               dz_hit, idle, revx, revy;
  logic signed [7:0]  mzx, mzy;
  logic [7:0]         ax, ay, hi, lo, speed;
  logic               g_low, g_high;
  logic signed [12:0] gdiff;
  logic signed [8:0]  gnum;
  logic signed [21:0] iprod_w;
  logic [21:0]        iprod_mag;
  logic [7:0]         den;
  logic [11:0]        gq;
  logic signed [31:0] gx_s, gy_s;
  logic [31:0]        accx_mag, accy_mag;
  logic [6:0]         satx, saty;

  assign sqx_w = 16'(mx_r) * 16'(mx_r);
  assign sqy_w = 16'(my_r) * 16'(my_r);
  assign r2_w  = 16'(cfg.deadzone_radius) * 16'(cfg.deadzone_radius);
  assign sqsum = {1'b0, sqx_r} + {1'b0, sqy_r};

  assign dz_hit = (cfg.deadzone_radius != 8'd0) && (sqsum <= r2_r);
  assign mzx    = dz_hit ? 8'sd0 : mx_r;
  assign mzy    = dz_hit ? 8'sd0 : my_r;
  assign idle   = (now_r - prevt_r) > {16'd0, cfg.idle_limit_ms};
  assign revx   = (mzx != 8'sd0) && (prevx_r != 8'sd0) && (mzx[7] != prevx_r[7]);
  assign revy   = (mzy != 8'sd0) && (prevy_r != 8'sd0) && (mzy[7] != prevy_r[7]);

  assign ax    = mzx[7] ? (~mzx + 8'd1) : mzx;
  assign ay    = mzy[7] ? (~mzy + 8'd1) : mzy;
  assign hi    = (ax > ay) ? ax : ay;
  assign lo    = (ax > ay) ? ay : ax;
  assign speed = hi + (lo >> 1);

  assign g_low   = speed_r <= cfg.speed_low;
  assign g_high  = speed_r >= cfg.speed_high;
  assign gdiff   = $signed({1'b0, cfg.gain_high}) - $signed({1'b0, cfg.gain_low});
  assign gnum    = $signed({1'b0, speed_r - cfg.speed_low});
  assign iprod_w = 22'(gdiff) * 22'(gnum);
  assign iprod_mag = iprod_r[21] ? (~iprod_r + 22'd1) : iprod_r;
  assign den     = cfg.speed_high - cfg.speed_low;
  assign gq      = quotx[11:0];

  assign gx_s = $signed({7'd0, quotx[24:0]});
  assign gy_s = $signed({7'd0, quoty[24:0]});

  assign accx_mag = accx_r[31] ? (~accx_r + 32'd1) : accx_r;
  assign accy_mag = accy_r[31] ? (~accy_r + 32'd1) : accy_r;
  assign satx = (quotx > 32'd127) ? 7'd127 : quotx[6:0];
  assign saty = (quoty > 32'd127) ? 7'd127 : quoty[6:0];

  // divider operand select
  assign div_start = (op == pmgs_pkg::OP_GAIN_DIV) || (op == pmgs_pkg::OP_SCALE_DIV) ||
                     (op == pmgs_pkg::OP_QUOT_DIV);
  always_comb begin
    unique case (op)
      pmgs_pkg::OP_GAIN_DIV: begin
        dvdx = DW'(iprod_mag);
        dvdy = DW'(iprod_mag);
        dvs  = DW'(den);
      end
      pmgs_pkg::OP_SCALE_DIV: begin
        dvdx = DW'(pxx_r);
        dvdy = DW'(pxy_r);
        dvs  = DENOM;
      end
      default: begin
        dvdx = accx_mag;
        dvdy = accy_mag;
        dvs  = DENOM;
      end
    endcase
  end

  pmgs_div #(.W(DW)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvdx), .divisor(dvs),
    .done(donex), .quot(quotx), .rem(remx)
  );

  pmgs_div #(.W(DW)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvdy), .divisor(dvs),
    .done(doney), .quot(quoty), .rem(remy)
  );

  // kept state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accx_r      <= '0;
      accy_r      <= '0;
      prevx_r     <= '0;
      prevy_r     <= '0;
      prevt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == pmgs_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (op)
        pmgs_pkg::OP_DEADZONE: begin
          accx_r  <= (idle || revx) ? 32'sd0 : accx_r;
          accy_r  <= (idle || revy) ? 32'sd0 : accy_r;
          prevx_r <= mzx;
          prevy_r <= mzy;
          prevt_r <= now_r;
        end
        pmgs_pkg::OP_ACCUM: begin
          accx_r <= accx_r + prodx_r;
          accy_r <= accy_r + prody_r;
        end
        pmgs_pkg::OP_QUOT_FIX: begin
          accx_r <= accx_r[31] ? -$signed(remx) : $signed(remx);
          accy_r <= accy_r[31] ? -$signed(remy) : $signed(remy);
        end
        default: ;
      endcase
    end
  end

  // per-item payload, no reset
  always_ff @(posedge clk) begin
    unique case (op)
      pmgs_pkg::OP_LOAD: begin
        mx_r  <= move_x;
        my_r  <= move_y;
        now_r <= now_ms;
      end
      pmgs_pkg::OP_SQUARE: begin
        sqx_r <= sqx_w[14:0];
        sqy_r <= sqy_w[14:0];
        r2_r  <= r2_w;
      end
      pmgs_pkg::OP_DEADZONE: begin
        mzx_r   <= mzx;
        mzy_r   <= mzy;
        speed_r <= speed;
      end
      pmgs_pkg::OP_GAIN_SEL: begin
        gain_r  <= g_low ? cfg.gain_low : cfg.gain_high;
        iprod_r <= iprod_w;
      end
      pmgs_pkg::OP_GAIN_FIX: begin
        gain_r <= iprod_r[21] ? (cfg.gain_low - gq) : (cfg.gain_low + gq);
      end
      pmgs_pkg::OP_SCALE: begin
        pxx_r <= 25'(gain_r) * 25'(cfg.axis_scale_x) + HALF;
        pxy_r <= 25'(gain_r) * 25'(cfg.axis_scale_y) + HALF;
      end
      pmgs_pkg::OP_MOVE: begin
        prodx_r <= 32'(mzx_r) * gx_s;
        prody_r <= 32'(mzy_r) * gy_s;
      end
      pmgs_pkg::OP_QUOT_FIX: begin
        resx_r <= accx_r[31] ? -$signed({1'b0, satx}) : $signed({1'b0, satx});
        resy_r <= accy_r[31] ? -$signed({1'b0, saty}) : $signed({1'b0, saty});
      end
      pmgs_pkg::OP_EMIT: begin
        outx_r <= resx_r;
        outy_r <= resy_r;
      end
      default: ;
    endcase
  end

  assign status.interp   = !g_low && !g_high;
  assign status.div_done = donex && doney;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_x     = outx_r;
  assign out_y     = outy_r;

endmodule

// ===== sv/pmgs_ctrl.sv =====
// Sequencer for one motion beat through the datapath.
module pmgs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pmgs_pkg::dp_status_t status,
  output pmgs_pkg::op_t        op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_DEADZONE,
    S_GAIN_SEL,
    S_GAIN_DIV,
    S_GAIN_WAIT,
    S_GAIN_FIX,
    S_SCALE,
    S_SCALE_DIV,
    S_SCALE_WAIT,
    S_MOVE,
    S_ACCUM,
    S_QUOT_DIV,
    S_QUOT_WAIT,
    S_QUOT_FIX,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = pmgs_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = pmgs_pkg::OP_LOAD;
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: begin
        op        = pmgs_pkg::OP_SQUARE;
        state_nxt = S_DEADZONE;
      end
      S_DEADZONE: begin
        op        = pmgs_pkg::OP_DEADZONE;
        state_nxt = S_GAIN_SEL;
      end
      S_GAIN_SEL: begin
        op        = pmgs_pkg::OP_GAIN_SEL;
        state_nxt = status.interp ? S_GAIN_DIV : S_SCALE;
      end
      S_GAIN_DIV: begin
        op        = pmgs_pkg::OP_GAIN_DIV;
        state_nxt = S_GAIN_WAIT;
      end
      S_GAIN_WAIT: begin
        if (status.div_done) state_nxt = S_GAIN_FIX;
      end
      S_GAIN_FIX: begin
        op        = pmgs_pkg::OP_GAIN_FIX;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        op        = pmgs_pkg::OP_SCALE;
        state_nxt = S_SCALE_DIV;
      end
      S_SCALE_DIV: begin
        op        = pmgs_pkg::OP_SCALE_DIV;
        state_nxt = S_SCALE_WAIT;
      end
      S_SCALE_WAIT: begin
        if (status.div_done) state_nxt = S_MOVE;
      end
      S_MOVE: begin
        op        = pmgs_pkg::OP_MOVE;
        state_nxt = S_ACCUM;
      end
      S_ACCUM: begin
        op        = pmgs_pkg::OP_ACCUM;
        state_nxt = S_QUOT_DIV;
      end
      S_QUOT_DIV: begin
        op        = pmgs_pkg::OP_QUOT_DIV;
        state_nxt = S_QUOT_WAIT;
      end
      S_QUOT_WAIT: begin
        if (status.div_done) state_nxt = S_QUOT_FIX;
      end
      S_QUOT_FIX: begin
        op        = pmgs_pkg::OP_QUOT_FIX;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          op        = pmgs_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== sv/pointer_motion_gain_shaper.sv =====
// Pointer motion gain shaper with sub-pixel accumulation.
// in_ch carries one motion beat (move_x, move_y, now_ms); out_ch returns one
// shaped beat (out_x, out_y) for every input beat, in order. Both channels move
// a beat when valid and ready are high at a rising clock edge.
// The cfg_ port writes register cfg_idx with cfg_data at any edge with cfg_we;
// write only while the block is idle.
// One beat is in flight at a time: in_ch.ready is high only while the
// sequencer waits for input, so the next beat is taken only once the
// previous result has been loaded into the output register. Each beat
// passes two or three divisions through the two-bit-per-cycle divider
// lanes, one per axis; the gain division is needed only when the speed
// falls between the two thresholds and the gain must be interpolated.
// The result sits in an output register, so a new input beat is taken while
// the previous result still waits; if the receiver stalls longer, the
// sequencer holds its finished result until the output register frees.
// Synchronous reset clears the accumulators, the previous-motion and time
// history, the output valid flag and restores all register defaults.
module pointer_motion_gain_shaper #(
  parameter int FRAC_DENOM = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  pmgs_in_if.sink     in_ch,
  pmgs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data
);

  pmgs_pkg::cfg_t       cfg_r, cfg_nxt;
  pmgs_pkg::op_t        op;
  pmgs_pkg::dp_status_t status;
  logic                 in_ready;

  // register file: decode the write, keep every other field
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (pmgs_pkg::reg_idx_t'(cfg_idx))
        pmgs_pkg::REG_DEADZONE_RADIUS: cfg_nxt.deadzone_radius = cfg_data[7:0];
        pmgs_pkg::REG_GAIN_LOW:        cfg_nxt.gain_low        = cfg_data[11:0];
        pmgs_pkg::REG_GAIN_HIGH:       cfg_nxt.gain_high       = cfg_data[11:0];
        pmgs_pkg::REG_SPEED_LOW:       cfg_nxt.speed_low       = cfg_data[7:0];
        pmgs_pkg::REG_SPEED_HIGH:      cfg_nxt.speed_high      = cfg_data[7:0];
        pmgs_pkg::REG_IDLE_LIMIT_MS:   cfg_nxt.idle_limit_ms   = cfg_data;
        pmgs_pkg::REG_AXIS_SCALE_X:    cfg_nxt.axis_scale_x    = cfg_data[11:0];
        pmgs_pkg::REG_AXIS_SCALE_Y:    cfg_nxt.axis_scale_y    = cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pmgs_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer: one step command per cycle, none while it waits for input, the dividers or the output register
  pmgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  // datapath owns the history, the dividers and the output register
  pmgs_dp #(.FRAC_DENOM(FRAC_DENOM)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .move_x    (in_ch.move_x),
    .move_y    (in_ch.move_y),
    .now_ms    (in_ch.now_ms),
    .op        (op),
    .status    (status),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== sim/pointer_motion_gain_shaper_tb.sv =====
module pointer_motion_gain_shaper_tb;
  import pmgs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 256;

  // One shaped beat as the output channel should present it
  typedef struct {
    logic signed [7:0] x;
    logic signed [7:0] y;
  } shaped_t;

  // Directed stimulus row: either a register write or a motion beat.
  // Motion rows with 'typed' set carry a hand-written result.
  typedef struct packed {
    logic              is_cfg;
    reg_idx_t          idx;
    logic [15:0]       data;
    logic signed [7:0] mx;
    logic signed [7:0] my;
    logic [31:0]       stamp;
    logic              typed;
    logic signed [7:0] ex;
    logic signed [7:0] ey;
  } plan_row_t;

  localparam int PLAN_LEN = 25;

  // Reset defaults first: zero motion, full-scale motion on both axes, then
  // each gain region, sign reversals, one-axis motion, the idle timeout just
  // past and exactly at the limit, and a timestamp wrap. After that: the widest
  // deadzone, a small deadzone at its rim, reversed thresholds and saturation
  // with the largest gain and axis factor.
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd0,    8'sd0,    32'd0,   1'b1, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd127,  8'sd127,  32'd1,   1'b1, 8'sd127, 8'sd127},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,  -8'sd128, -8'sd128,  32'd2,   1'b1, -8'sd127, -8'sd127},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd4,    8'sd0,    32'd3,   1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd5,    8'sd2,    32'd4,   1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd24,   8'sd0,    32'd5,   1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,  -8'sd3,    8'sd3,    32'd6,   1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd3,   -8'sd3,    32'd7,   1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd0,   -8'sd5,    32'd8,   1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd7,    8'sd7,    32'd59,  1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd7,    8'sd7,    32'd109, 1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd2,    8'sd1,    32'hFFFF_FFF0, 1'b0, 8'sd0, 8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd2,    8'sd1,    32'h5,   1'b0, 8'sd0,   8'sd0},
    '{1'b1, REG_DEADZONE_RADIUS, 16'd255, 8'sd0,    8'sd0,    32'd0,   1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,  -8'sd128,  8'sd127,  32'h10,  1'b1, 8'sd0,   8'sd0},
    '{1'b1, REG_DEADZONE_RADIUS, 16'd5,   8'sd0,    8'sd0,    32'd0,   1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd3,    8'sd4,    32'h11,  1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd4,   -8'sd4,    32'h12,  1'b0, 8'sd0,   8'sd0},
    '{1'b1, REG_SPEED_LOW,       16'd30,  8'sd0,    8'sd0,    32'd0,   1'b0, 8'sd0,   8'sd0},
    '{1'b1, REG_SPEED_HIGH,      16'd10,  8'sd0,    8'sd0,    32'd0,   1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd20,   8'sd0,    32'h13,  1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,  -8'sd40,   8'sd0,    32'h14,  1'b0, 8'sd0,   8'sd0},
    '{1'b1, REG_GAIN_HIGH,       16'd4095, 8'sd0,   8'sd0,    32'd0,   1'b0, 8'sd0,   8'sd0},
    '{1'b1, REG_AXIS_SCALE_X,    16'd4095, 8'sd0,   8'sd0,    32'd0,   1'b0, 8'sd0,   8'sd0},
    '{1'b0, REG_DEADZONE_RADIUS, 16'd0,   8'sd127, -8'sd128,  32'h15,  1'b1, 8'sd127, -8'sd127}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_data;

  pmgs_in_if  in_bus ();
  pmgs_out_if out_bus ();

  pointer_motion_gain_shaper #(
    .FRAC_DENOM(FRAC)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // Shadow of the block: register file, sub-pixel accumulators, history
  cfg_t        regs;
  longint      acc_x;
  longint      acc_y;
  int          last_x;
  int          last_y;
  logic [31:0] last_ms;

  // Shaped beats still owed by the block, oldest first
  shaped_t     motion_due[$];

  int unsigned fail_count;
  int          gap_pct;    // chance of a sender gap after each beat
  int          stall_pct;  // chance of a receiver stall burst per cycle
  bit          tail_calm;  // no idling at all in the closing stretch

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Clamp a quotient to the report range
  function automatic logic signed [7:0] clip_report(input longint q);
    if (q > 127) return 8'sd127;
    if (q < -127) return -8'sd127;
    return q[7:0];
  endfunction

  // Work out the shaped beat for one motion sample and advance the shadow state
  function automatic void shape_motion(input logic signed [7:0] mx_in,
                                       input logic signed [7:0] my_in,
                                       input logic [31:0] stamp,
                                       output logic signed [7:0] rx,
                                       output logic signed [7:0] ry);
    int          mx, my, ax, ay, hi, lo, speed, gain, num, den, rad;
    longint      gx, gy, qx, qy;
    logic [31:0] silence;
    mx = mx_in;
    my = my_in;
    rad = int'(regs.deadzone_radius);
    // Circular deadzone: drop small motion on both axes
    if (rad != 0 && mx * mx + my * my <= rad * rad) begin
      mx = 0;
      my = 0;
    end
    // Idle timeout, with wrap-around time difference
    silence = stamp - last_ms;
    if (silence > 32'(regs.idle_limit_ms)) begin
      acc_x = 0;
      acc_y = 0;
    end
    // Direction reversal per axis drops the leftover fraction
    if (mx != 0 && last_x != 0 && ((mx < 0) != (last_x < 0))) acc_x = 0;
    if (my != 0 && last_y != 0 && ((my < 0) != (last_y < 0))) acc_y = 0;
    last_x = mx;
    last_y = my;
    last_ms = stamp;
    // Speed estimate: larger magnitude plus half the smaller
    ax = (mx < 0) ? -mx : mx;
    ay = (my < 0) ? -my : my;
    hi = (ax > ay) ? ax : ay;
    lo = (ax > ay) ? ay : ax;
    speed = hi + (lo >> 1);
    if (speed <= int'(regs.speed_low)) begin
      gain = int'(regs.gain_low);
    end else if (speed >= int'(regs.speed_high)) begin
      gain = int'(regs.gain_high);
    end else begin
      num = speed - int'(regs.speed_low);
      den = int'(regs.speed_high) - int'(regs.speed_low);
      if (den < 1) den = 1;
      gain = int'(regs.gain_low) + ((int'(regs.gain_high) - int'(regs.gain_low)) * num) / den;
    end
    gx = (longint'(gain) * longint'(regs.axis_scale_x) + FRAC / 2) / FRAC;
    gy = (longint'(gain) * longint'(regs.axis_scale_y) + FRAC / 2) / FRAC;
    acc_x += longint'(mx) * gx;
    acc_y += longint'(my) * gy;
    // Whole counts leave the accumulator even when the report saturates
    qx = acc_x / FRAC;
    qy = acc_y / FRAC;
    acc_x -= qx * FRAC;
    acc_y -= qy * FRAC;
    rx = clip_report(qx);
    ry = clip_report(qy);
  endfunction

  // Present one motion beat, hold it until taken, then log what it owes
  task automatic send_motion(input logic signed [7:0] mx, input logic signed [7:0] my,
                             input logic [31:0] stamp, input logic typed,
                             input logic signed [7:0] ex, input logic signed [7:0] ey);
    shaped_t owed;
    cfg_we        <= 1'b0;
    in_bus.valid  <= 1'b1;
    in_bus.move_x <= mx;
    in_bus.move_y <= my;
    in_bus.now_ms <= stamp;
    do @(posedge clk); while (!in_bus.ready);
    shape_motion(mx, my, stamp, owed.x, owed.y);
    if (typed) begin
      owed.x = ex;
      owed.y = ey;
    end
    motion_due.push_back(owed);
  endtask

  // Sender gap: a chain of short bursts so that idle time lands on every
  // step of the block's sequence, not only on the input wait
  task automatic pause_source();
    int idle_cycles;
    idle_cycles = 0;
    if (!tail_calm && $urandom_range(0, 99) < gap_pct) begin
      repeat ($urandom_range(1, 5)) idle_cycles += $urandom_range(1, 14);
      in_bus.valid <= 1'b0;
      repeat (idle_cycles) @(posedge clk);
    end
  endtask

  // Drop valid and the write strobe, then wait until every owed beat is back
  task automatic settle();
    in_bus.valid <= 1'b0;
    cfg_we       <= 1'b0;
    @(posedge clk);
    while (motion_due.size() != 0) @(posedge clk);
  endtask

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_DEADZONE_RADIUS: regs.deadzone_radius = val[7:0];
      REG_GAIN_LOW:        regs.gain_low        = val[11:0];
      REG_GAIN_HIGH:       regs.gain_high       = val[11:0];
      REG_SPEED_LOW:       regs.speed_low       = val[7:0];
      REG_SPEED_HIGH:      regs.speed_high      = val[7:0];
      REG_IDLE_LIMIT_MS:   regs.idle_limit_ms   = val;
      REG_AXIS_SCALE_X:    regs.axis_scale_x    = val[11:0];
      REG_AXIS_SCALE_Y:    regs.axis_scale_y    = val[11:0];
    endcase
    @(posedge clk);
  endtask

  // Receiver: ready, with random stall bursts
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (!tail_calm && $urandom_range(0, 99) < stall_pct) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 13);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Scoreboard: every accepted output beat against the oldest owed beat
  always @(posedge clk) begin : check_out
    shaped_t owed;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (motion_due.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual out_x %0d out_y %0d",
                 $time, out_bus.out_x, out_bus.out_y);
        fail_count++;
      end else begin
        owed = motion_due.pop_front();
        if (out_bus.out_x !== owed.x) begin
          $display("%0t ns: out_x mismatch, expected %0d, actual %0d",
                   $time, owed.x, out_bus.out_x);
          fail_count++;
        end
        if (out_bus.out_y !== owed.y) begin
          $display("%0t ns: out_y mismatch, expected %0d, actual %0d",
                   $time, owed.y, out_bus.out_y);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    cfg_t              knobs;
    reg_idx_t          ri;
    logic [15:0]       val;
    logic signed [7:0] mx, my;
    logic [31:0]       stamp;
    int                stroke_left, dir_x, dir_y, peak, n_items;

    // Drive every input to a known value before the first edge
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_DEADZONE_RADIUS;
    cfg_data       <= '0;
    in_bus.valid   <= 1'b0;
    in_bus.move_x  <= '0;
    in_bus.move_y  <= '0;
    in_bus.now_ms  <= '0;
    fail_count  = 0;
    gap_pct     = 25;
    stall_pct   = 10;
    tail_calm   = 1'b0;
    regs        = CFG_RESET;
    acc_x       = 0;
    acc_y       = 0;
    last_x      = 0;
    last_y      = 0;
    last_ms     = '0;
    stroke_left = 0;
    dir_x       = 1;
    dir_y       = 0;
    peak        = 1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].is_cfg) begin
        settle();
        write_reg(PLAN[i].idx, PLAN[i].data);
      end else begin
        send_motion(PLAN[i].mx, PLAN[i].my, PLAN[i].stamp, PLAN[i].typed,
                    PLAN[i].ex, PLAN[i].ey);
        pause_source();
      end
    end
    stamp = 32'h15;

    // Random part in phases: all-zero registers, all-max registers, max
    // without deadzone, then realistic settings. The last phase runs with
    // no idling on either side.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: knobs = '0;
        1: knobs = '1;
        2: begin
          knobs = '1;
          knobs.deadzone_radius = '0;
        end
        default: begin
          knobs.deadzone_radius = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 255)) :
                                  ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 12)) :
                                  8'd0;
          knobs.gain_low     = $urandom_range(0, 1) ? 12'($urandom_range(16, 512))
                                                    : 12'($urandom_range(0, 4095));
          knobs.gain_high    = $urandom_range(0, 1) ? 12'($urandom_range(16, 512))
                                                    : 12'($urandom_range(0, 4095));
          knobs.speed_low    = 8'($urandom_range(0, 40));
          knobs.speed_high   = 8'($urandom_range(0, 80));
          case ($urandom_range(0, 3))
            0:       knobs.idle_limit_ms = 16'($urandom_range(0, 30));
            1:       knobs.idle_limit_ms = 16'hFFFF;
            2:       knobs.idle_limit_ms = 16'($urandom_range(0, 65535));
            default: knobs.idle_limit_ms = 16'($urandom_range(31, 2000));
          endcase
          knobs.axis_scale_x = $urandom_range(0, 1) ? 12'($urandom_range(64, 512))
                                                    : 12'($urandom_range(0, 4095));
          knobs.axis_scale_y = $urandom_range(0, 1) ? 12'($urandom_range(64, 512))
                                                    : 12'($urandom_range(0, 4095));
        end
      endcase

      // Registers change only with nothing in flight
      settle();
      for (int r = 0; r < 8; r++) begin
        ri = reg_idx_t'(r);
        case (ri)
          REG_DEADZONE_RADIUS: val = 16'(knobs.deadzone_radius);
          REG_GAIN_LOW:        val = 16'(knobs.gain_low);
          REG_GAIN_HIGH:       val = 16'(knobs.gain_high);
          REG_SPEED_LOW:       val = 16'(knobs.speed_low);
          REG_SPEED_HIGH:      val = 16'(knobs.speed_high);
          REG_IDLE_LIMIT_MS:   val = knobs.idle_limit_ms;
          REG_AXIS_SCALE_X:    val = 16'(knobs.axis_scale_x);
          REG_AXIS_SCALE_Y:    val = 16'(knobs.axis_scale_y);
        endcase
        write_reg(ri, val);
      end

      // Some phases run with no idling at all
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      tail_calm = (p == 7);
      n_items   = (p < 3) ? 40 : 118;

      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < 12) begin
          // Noise: any motion, erratic time
          mx = 8'($urandom);
          my = 8'($urandom);
          if ($urandom_range(0, 3) == 0) stamp = $urandom;
          else stamp += $urandom_range(0, 40);
        end else begin
          // Stroke: steady direction, random magnitude, small time steps
          if (stroke_left == 0) begin
            stroke_left = $urandom_range(3, 30);
            dir_x = int'($urandom_range(0, 2)) - 1;
            dir_y = int'($urandom_range(0, 2)) - 1;
            peak  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 20)
                                               : $urandom_range(21, 127);
            // Open a stroke after a pause past the idle limit, right at it,
            // or straight on
            case ($urandom_range(0, 5))
              0:       stamp += 32'(regs.idle_limit_ms) + $urandom_range(1, 300);
              1:       stamp += 32'(regs.idle_limit_ms);
              default: stamp += $urandom_range(0, 12);
            endcase
          end else begin
            stamp += $urandom_range(0, 12);
          end
          stroke_left--;
          // Occasional jolt: flip one axis mid-stroke
          if ($urandom_range(0, 19) == 0) dir_x = -dir_x;
          if ($urandom_range(0, 19) == 0) dir_y = -dir_y;
          mx = 8'(dir_x * int'($urandom_range(0, peak)));
          my = 8'(dir_y * int'($urandom_range(0, peak)));
        end
        send_motion(mx, my, stamp, 1'b0, 8'sd0, 8'sd0);
        pause_source();
      end
    end

    // Drain, then leave room for any stray beat to show up
    settle();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pmgs_pkg.sv
sv/pmgs_if.sv
sv/pmgs_div.sv
sv/pmgs_dp.sv
sv/pmgs_ctrl.sv
sv/pointer_motion_gain_shaper.sv
sim/pointer_motion_gain_shaper_tb.sv
